### rtl/rcsf_pkg.sv
// rcsf_pkg: shared types and constants for the RTMP chunk stream framer.
// No dependencies.
package rcsf_pkg;

  localparam int BUF_BYTES = 14;          // longest header run: 3 basic + 11 message
  localparam int CNT_W     = 4;           // holds 0..BUF_BYTES
  localparam int MH_BYTES  = 11;          // format 0 message header

  localparam logic        ACT_BEGIN  = 1'b0;
  localparam logic        ACT_DATA   = 1'b1;
  localparam logic [1:0]  FMT_FULL   = 2'd0;
  localparam logic [1:0]  FMT_NOSID  = 2'd1;
  localparam logic [1:0]  FMT_STAMP  = 2'd2;
  localparam logic [1:0]  FMT_CONT   = 2'd3;

  localparam logic [16:0] MAX_CHAN    = 17'd65599;
  localparam logic [16:0] MAX_CHUNK   = 17'd65536;
  localparam logic [16:0] CHUNK_RESET = 17'd128;
  localparam logic [16:0] ONE_BYTE_LIM = 17'd64;   // ids below take one byte
  localparam logic [16:0] TWO_BYTE_LIM = 17'd320;  // ids below take two bytes
  localparam logic [16:0] CHAN_BIAS    = 17'd64;

  typedef struct packed {
    logic load;    // capture the incoming item into the byte buffer
    logic shift;   // head byte transferred, advance the buffer
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_bytes;  // bytes the pending item produces
    logic             end_msg;  // its last byte finishes the message
  } dp_stat_t;

endpackage

### rtl/rcsf_if.sv
// rcsf_if: valid/ready channel interfaces for input items and framed bytes.
// Depends on nothing.
interface rcsf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [1:0]  fmt;
  logic [16:0] chan;
  logic [23:0] stamp;
  logic [23:0] msg_len;
  logic [7:0]  kind;
  logic [31:0] stream_id;
  logic [7:0]  payload;

  modport source (output valid, action, fmt, chan, stamp, msg_len, kind, stream_id,
                  payload, input ready);
  modport sink   (input valid, action, fmt, chan, stamp, msg_len, kind, stream_id,
                  payload, output ready);
  modport mon    (input valid, ready, action, fmt, chan, stamp, msg_len, kind,
                  stream_id, payload);
endinterface

interface rcsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       msg_end;

  modport source (output valid, out_byte, run_last, msg_end, input ready);
  modport sink   (input valid, out_byte, run_last, msg_end, output ready);
  modport mon    (input valid, ready, out_byte, run_last, msg_end);
endinterface

### rtl/rcsf_ctrl.sv
// rcsf_ctrl: handshake controller; counts out the bytes of the current run.
// Depends on rcsf_pkg.
module rcsf_ctrl
  import rcsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      in_ready,
  output logic      out_valid,
  output logic      run_last,
  output logic      msg_end
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             end_r, end_nxt;

  assign out_valid = (state_r == ST_SEND);
  // take a new item when idle or once the last byte of the run is leaving
  assign in_ready  = (state_r == ST_IDLE) || (cnt_r == CNT_W'(1) && out_ready);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.shift = out_valid && out_ready;
  assign run_last  = (cnt_r == CNT_W'(1));
  assign msg_end   = end_r && (cnt_r == CNT_W'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    if (cmd.load) begin
      cnt_nxt = stat.n_bytes;
      end_nxt = stat.end_msg;
    end else if (cmd.shift) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cnt_nxt != '0) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (cnt_nxt == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

### rtl/rcsf_dp.sv
// rcsf_dp: framing datapath; header assembly, message/chunk counters, byte buffer.
// Depends on rcsf_pkg.
module rcsf_dp
  import rcsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        action,
  input  logic [1:0]  fmt,
  input  logic [16:0] chan,
  input  logic [23:0] stamp,
  input  logic [23:0] msg_len,
  input  logic [7:0]  kind,
  input  logic [31:0] stream_id,
  input  logic [7:0]  payload,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  output logic [7:0]  out_byte
);

  logic [16:0] chunk_size_r, chunk_size_nxt;
  logic [16:0] open_chan_r, open_chan_nxt;
  logic [23:0] bytes_left_r, bytes_left_nxt;
  logic [16:0] chunk_pos_r, chunk_pos_nxt;
  logic [7:0]  buf_r [BUF_BYTES];
  logic [7:0]  buf_nxt [BUF_BYTES];

  logic [16:0] eff_chunk, chan_sat, bh_chan, chan_off;
  logic [1:0]  bh_fmt;
  logic        is_begin, live, cont_due;
  logic [7:0]  bh [3];
  logic [1:0]  bh_n;
  logic [7:0]  mh [MH_BYTES];
  logic [3:0]  mh_n;
  logic [CNT_W-1:0] bh_cnt;
  logic [3:0]  mh_idx;
  logic [7:0]  ld [BUF_BYTES];

  always_comb begin
    // chunk size zero acts as one, oversize clamps
    if (chunk_size_r == '0)          eff_chunk = 17'd1;
    else if (chunk_size_r > MAX_CHUNK) eff_chunk = MAX_CHUNK;
    else                              eff_chunk = chunk_size_r;
    cont_due = (chunk_pos_r >= eff_chunk);
    chan_sat = (chan > MAX_CHAN) ? MAX_CHAN : chan;
    is_begin = (action == ACT_BEGIN);
    live     = (bytes_left_r != '0);

    bh_fmt   = is_begin ? fmt : FMT_CONT;
    bh_chan  = is_begin ? chan_sat : open_chan_r;
    chan_off = bh_chan - CHAN_BIAS;
    bh[0] = '0; bh[1] = '0; bh[2] = '0;
    if (bh_chan < ONE_BYTE_LIM) begin
      bh[0] = {bh_fmt, bh_chan[5:0]};
      bh_n  = 2'd1;
    end else if (bh_chan < TWO_BYTE_LIM) begin
      bh[0] = {bh_fmt, 6'd0};
      bh[1] = chan_off[7:0];
      bh_n  = 2'd2;
    end else begin
      bh[0] = {bh_fmt, 6'd1};
      bh[1] = chan_off[7:0];
      bh[2] = chan_off[15:8];
      bh_n  = 2'd3;
    end

    // message header, big-endian
    mh[0]  = is_begin ? stamp[23:16] : payload;
    mh[1]  = stamp[15:8];
    mh[2]  = stamp[7:0];
    mh[3]  = msg_len[23:16];
    mh[4]  = msg_len[15:8];
    mh[5]  = msg_len[7:0];
    mh[6]  = kind;
    mh[7]  = stream_id[31:24];
    mh[8]  = stream_id[23:16];
    mh[9]  = stream_id[15:8];
    mh[10] = stream_id[7:0];
    if (is_begin) begin
      case (fmt)
        FMT_FULL:  mh_n = 4'd11;
        FMT_NOSID: mh_n = 4'd7;
        FMT_STAMP: mh_n = 4'd3;
        default:   mh_n = 4'd0;
      endcase
    end else begin
      mh_n = 4'd1;
    end

    bh_cnt = (is_begin || cont_due) ? CNT_W'(bh_n) : '0;

    for (int k = 0; k < BUF_BYTES; k++) begin
      mh_idx = CNT_W'(k) - bh_cnt;
      ld[k]  = '0;
      if (CNT_W'(k) >= bh_cnt && mh_idx < 4'(MH_BYTES)) ld[k] = mh[mh_idx];
    end
    for (int k = 0; k < 3; k++) begin
      if (CNT_W'(k) < bh_cnt) ld[k] = bh[k];
    end

    if (is_begin)  stat.n_bytes = bh_cnt + CNT_W'(mh_n);
    else if (live) stat.n_bytes = bh_cnt + CNT_W'(1);
    else           stat.n_bytes = '0;     // no open message: dropped
    stat.end_msg = is_begin ? (msg_len == '0) : (bytes_left_r == 24'd1);
  end

  always_comb begin
    chunk_size_nxt = cfg_wr_en ? cfg_wr_data : chunk_size_r;
    open_chan_nxt  = open_chan_r;
    bytes_left_nxt = bytes_left_r;
    chunk_pos_nxt  = chunk_pos_r;
    for (int k = 0; k < BUF_BYTES; k++) buf_nxt[k] = buf_r[k];
    if (cmd.load) begin
      for (int k = 0; k < BUF_BYTES; k++) buf_nxt[k] = ld[k];
      if (is_begin) begin
        open_chan_nxt  = chan_sat;
        bytes_left_nxt = msg_len;
        chunk_pos_nxt  = '0;
      end else if (live) begin
        bytes_left_nxt = bytes_left_r - 24'd1;
        chunk_pos_nxt  = cont_due ? 17'd1 : chunk_pos_r + 17'd1;
      end
    end else if (cmd.shift) begin
      for (int k = 0; k < BUF_BYTES - 1; k++) buf_nxt[k] = buf_r[k+1];
      buf_nxt[BUF_BYTES-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= CHUNK_RESET;
      open_chan_r  <= '0;
      bytes_left_r <= '0;
      chunk_pos_r  <= '0;
    end else begin
      chunk_size_r <= chunk_size_nxt;
      open_chan_r  <= open_chan_nxt;
      bytes_left_r <= bytes_left_nxt;
      chunk_pos_r  <= chunk_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < BUF_BYTES; k++) buf_r[k] <= buf_nxt[k];
  end

  assign out_byte = buf_r[0];

endmodule

### rtl/rtmp_chunk_stream_framer_unit.sv
// RTMP chunk stream framer, top level. Depends on rcsf_pkg, rcsf_if, rcsf_ctrl, rcsf_dp.
// Output is registered: an item's first byte is offered in the cycle after its transfer.
// An item producing n bytes (1..14) holds the output until its last byte leaves; the
// next item is taken as it leaves, so bytes pass one per cycle unless either side stalls.
// Reset: synchronous, active low; closes any message, chunk size returns to 128.
module rtmp_chunk_stream_framer_unit
  import rcsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rcsf_in_if.sink     in_ch,
  rcsf_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);

  ctrl_cmd_t cmd;   // controller -> datapath
  dp_stat_t  stat;  // datapath -> controller

  // Controller owns the handshake: it counts the bytes of the current run
  // and flags run_last / msg_end on the final one.
  rcsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .run_last  (out_ch.run_last),
    .msg_end   (out_ch.msg_end)
  );

  // Datapath builds basic and message headers, inserts continuation headers
  // at chunk boundaries and holds the outgoing bytes in a shift buffer.
  rcsf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (in_ch.action),
    .fmt         (in_ch.fmt),
    .chan        (in_ch.chan),
    .stamp       (in_ch.stamp),
    .msg_len     (in_ch.msg_len),
    .kind        (in_ch.kind),
    .stream_id   (in_ch.stream_id),
    .payload     (in_ch.payload),
    .cmd         (cmd),
    .stat        (stat),
    .out_byte    (out_ch.out_byte)
  );

endmodule

### rtl/rcsf_checker.sv
// rcsf_checker: port-level assertions for the framer, bound to the top level.
// Depends on rtmp_chunk_stream_framer_unit.
module rcsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_msg_end
);

  // message end only ever marks the last byte of a run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_end |-> out_run_last)
    else $error("msg_end without run_last");

  // no new item while more bytes of the current run are pending
  a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input taken mid-run");

  // a stalled byte holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output changed under stall");

  // a run that is not finished continues after its transfer
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("run cut short");

endmodule

bind rtmp_chunk_stream_framer_unit rcsf_checker u_rcsf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .out_run_last (out_ch.run_last),
  .out_msg_end  (out_ch.msg_end)
);

### tb/rcsf_stream_checker.sv
`timescale 1ns / 1ps
// rcsf_stream_checker: watches the item, byte and config ports of the chunk stream framer,
// predicts every framed byte and compares it. Depends on rcsf_pkg and rcsf_if.
module rcsf_stream_checker
  import rcsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rcsf_in_if.mon      in_mon,
  rcsf_out_if.mon     out_mon,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          bytes_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       msg_end;
  } framed_byte_t;

  framed_byte_t expected_bytes[$];
  logic [7:0]   burst[$];       // bytes one item produces, in order

  logic [16:0] chunk_size;
  logic [16:0] open_chan;
  logic [16:0] chunk_fill;
  logic [23:0] owed;

  function automatic logic [16:0] chunk_limit(input logic [16:0] size);
    if (size == '0) return 17'd1;
    if (size > MAX_CHUNK) return MAX_CHUNK;
    return size;
  endfunction

  task automatic add_basic(input logic [1:0] fmt, input logic [16:0] id);
    logic [16:0] biased;
    biased = id - CHAN_BIAS;
    if (id < ONE_BYTE_LIM) begin
      burst.push_back({fmt, id[5:0]});
    end else if (id < TWO_BYTE_LIM) begin
      burst.push_back({fmt, 6'd0});
      burst.push_back(biased[7:0]);
    end else begin
      // three-byte form: id-64 little-endian
      burst.push_back({fmt, 6'd1});
      burst.push_back(biased[7:0]);
      burst.push_back(biased[15:8]);
    end
  endtask

  task automatic frame_item();
    logic [16:0] id;
    logic        closes;
    logic        is_last;
    burst.delete();
    closes = 1'b0;
    if (in_mon.action == ACT_BEGIN) begin
      id = (in_mon.chan > MAX_CHAN) ? MAX_CHAN : in_mon.chan;
      add_basic(in_mon.fmt, id);
      if (in_mon.fmt != FMT_CONT) begin
        burst.push_back(in_mon.stamp[23:16]);
        burst.push_back(in_mon.stamp[15:8]);
        burst.push_back(in_mon.stamp[7:0]);
      end
      if (in_mon.fmt == FMT_FULL || in_mon.fmt == FMT_NOSID) begin
        burst.push_back(in_mon.msg_len[23:16]);
        burst.push_back(in_mon.msg_len[15:8]);
        burst.push_back(in_mon.msg_len[7:0]);
        burst.push_back(in_mon.kind);
      end
      if (in_mon.fmt == FMT_FULL) begin
        burst.push_back(in_mon.stream_id[31:24]);
        burst.push_back(in_mon.stream_id[23:16]);
        burst.push_back(in_mon.stream_id[15:8]);
        burst.push_back(in_mon.stream_id[7:0]);
      end
      open_chan  = id;
      owed       = in_mon.msg_len;
      chunk_fill = '0;
      closes     = (in_mon.msg_len == '0);
    end else if (owed != '0) begin
      if (chunk_fill >= chunk_limit(chunk_size)) begin
        add_basic(FMT_CONT, open_chan);
        chunk_fill = '0;
      end
      burst.push_back(in_mon.payload);
      chunk_fill = chunk_fill + 17'd1;
      owed       = owed - 24'd1;
      closes     = (owed == '0);
    end
    foreach (burst[k]) begin
      is_last = (k == burst.size() - 1);
      expected_bytes.push_back({burst[k], is_last, is_last && closes});
    end
  endtask

  always @(posedge clk) begin
    framed_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      chunk_size    = CHUNK_RESET;
      open_chan     = '0;
      chunk_fill    = '0;
      owed          = '0;
      fail_count    = 0;
      bytes_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected byte, expected none actual %02h", $time,
                   out_mon.out_byte);
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_mon.out_byte !== want.data) begin
            fail_count++;
            $display("%0t: out_byte mismatch, expected %02h actual %02h", $time,
                     want.data, out_mon.out_byte);
          end
          if (out_mon.run_last !== want.run_last) begin
            fail_count++;
            $display("%0t: run_last mismatch, expected %0b actual %0b", $time,
                     want.run_last, out_mon.run_last);
          end
          if (out_mon.msg_end !== want.msg_end) begin
            fail_count++;
            $display("%0t: msg_end mismatch, expected %0b actual %0b", $time,
                     want.msg_end, out_mon.msg_end);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) frame_item();
      if (cfg_wr_en) chunk_size = cfg_wr_data;
    end
    pending = expected_bytes.size();
  end

endmodule

### tb/rtmp_chunk_stream_framer_unit_tb.sv
`timescale 1ns / 1ps
// rtmp_chunk_stream_framer_unit_tb: drives items, random stalls and chunk sizes into the
// framer; rcsf_stream_checker predicts and compares. Depends on rcsf_pkg, rcsf_if.
module rtmp_chunk_stream_framer_unit_tb;
  import rcsf_pkg::*;

  localparam int STALL_LIMIT  = 3000;  // cycles with no transfer or config write before giving up
  localparam int SETTLE       = 20;    // drain pause before a config write and at the end
  localparam int LONG_HOLD    = 250;   // receiver back-pressure stretch
  localparam int PHASE_ITEMS  = 55;

  typedef struct {
    logic        action;
    logic [1:0]  fmt;
    logic [16:0] chan;
    logic [23:0] stamp;
    logic [23:0] msg_len;
    logic [7:0]  kind;
    logic [31:0] stream_id;
    logic [7:0]  payload;
  } framer_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  rcsf_in_if  in_ch();
  rcsf_out_if out_ch();

  int fail_count;
  int pending;
  int bytes_checked;

  int items_sent = 0;    // transfers the framer acts on (dropped payload not counted)
  int settings   = 0;    // chunk size writes
  int delivered  = 0;    // output transfers seen by the receiver
  int holds      = 0;
  bit tx_steady  = 1'b0; // sender offers back to back
  bit rx_steady  = 1'b0; // receiver stalls only for the long hold-offs

  rtmp_chunk_stream_framer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  rcsf_stream_checker frame_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Item builders. Fields the framer ignores carry random noise.
  // ---------------------------------------------------------------------------
  function automatic framer_item_t begin_item(input logic [1:0] fmt, input logic [16:0] chan,
                                              input logic [23:0] stamp,
                                              input logic [23:0] msg_len,
                                              input logic [7:0] kind,
                                              input logic [31:0] stream_id);
    framer_item_t it;
    it.action    = ACT_BEGIN;
    it.fmt       = fmt;
    it.chan      = chan;
    it.stamp     = stamp;
    it.msg_len   = msg_len;
    it.kind      = kind;
    it.stream_id = stream_id;
    it.payload   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic framer_item_t data_item(input logic [7:0] payload);
    framer_item_t it;
    it.action    = ACT_DATA;
    it.fmt       = 2'($urandom_range(0, 3));
    it.chan      = 17'($urandom());
    it.stamp     = 24'($urandom());
    it.msg_len   = 24'($urandom());
    it.kind      = 8'($urandom());
    it.stream_id = $urandom();
    it.payload   = payload;
    return it;
  endfunction

  // Spread ids over the one, two and three byte basic header forms plus saturation.
  function automatic logic [16:0] pick_chan();
    case ($urandom_range(0, 4))
      0:       return 17'($urandom_range(0, 63));
      1:       return 17'($urandom_range(64, 319));
      2:       return 17'($urandom_range(320, 65599));
      3:       return 17'($urandom_range(65600, 131071));
      default: return 17'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after transfer.
  // valid is left high so a back-to-back item needs no second assignment.
  // ---------------------------------------------------------------------------
  task automatic send_item(input framer_item_t it);
    int gap;
    gap = tx_steady ? 0 : int'($urandom_range(0, 19));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action    <= it.action;
    in_ch.fmt       <= it.fmt;
    in_ch.chan      <= it.chan;
    in_ch.stamp     <= it.stamp;
    in_ch.msg_len   <= it.msg_len;
    in_ch.kind      <= it.kind;
    in_ch.stream_id <= it.stream_id;
    in_ch.payload   <= it.payload;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready === 1'b1));
    @(negedge clk);
  endtask

  // Chunk size goes in only with nothing in flight. A dropped payload byte gives no
  // result, so a short pause before the write lets the registered output settle.
  task automatic set_chunk(input logic [16:0] size);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_data <= size;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings++;
  endtask

  // One message: mostly well formed with every payload byte, some cut short, some with
  // huge lengths that the next begin abandons, and a stray byte now and then after close.
  task automatic send_message();
    logic [23:0] len;
    int          n_send;
    bit          big;
    big = ($urandom_range(0, 99) < 12);
    len = big ? 24'($urandom_range(0, 24'hFFFFFF)) : 24'($urandom_range(0, 24));
    n_send = big ? int'($urandom_range(0, 8)) : int'(len);
    if (!big && $urandom_range(0, 9) == 0) n_send = int'($urandom_range(0, len));
    send_item(begin_item(2'($urandom_range(0, 3)), pick_chan(), 24'($urandom()), len,
                         8'($urandom()), $urandom()));
    items_sent++;
    repeat (n_send) begin
      send_item(data_item(8'($urandom_range(0, 255))));
      items_sent++;
    end
    // message closed: this byte must vanish
    if (n_send == len && $urandom_range(0, 4) == 0) send_item(data_item(8'($urandom())));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall per byte, steady stretches, and two long hold-offs that
  // fill the framer and push back on the sender.
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready));
      delivered++;
      if (delivered == 150 || delivered == 900) begin
        gap = LONG_HOLD;
        holds++;
      end else if (rx_steady) begin
        gap = 0;
      end else begin
        gap = int'($urandom_range(0, 19));
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run if nothing moves on any port for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("rtmp_chunk_stream_framer_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [16:0] sizes [9];
    int          phase_start;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_DATA;
    in_ch.fmt       = FMT_FULL;
    in_ch.chan      = '0;
    in_ch.stamp     = '0;
    in_ch.msg_len   = '0;
    in_ch.kind      = '0;
    in_ch.stream_id = '0;
    in_ch.payload   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: default chunk size 128 ---
    send_item(data_item(8'h5A));  // nothing open yet: dropped
    // full header, all-ones stamp, kind and stream id, one-byte id
    send_item(begin_item(FMT_FULL, 17'd2, 24'hFFFFFF, 24'd3, 8'hFF, 32'hFFFFFFFF));
    send_item(data_item(8'h00));
    send_item(data_item(8'hFF));
    send_item(data_item(8'h5A));
    // zero-length message: end flag rides on the last header byte
    send_item(begin_item(FMT_NOSID, 17'd63, 24'h000000, 24'd0, 8'h00, 32'h0));
    // two-byte id, stamp-only header
    send_item(begin_item(FMT_STAMP, 17'd64, 24'h123456, 24'd1, 8'h14, 32'h0));
    send_item(data_item(8'hC3));
    // header-less start, left open then abandoned by the next begin
    send_item(begin_item(FMT_CONT, 17'd319, 24'h0, 24'hFFFFFF, 8'h00, 32'h0));
    send_item(data_item(8'h01));
    // three-byte id forms, top id and a saturated one
    send_item(begin_item(FMT_FULL, 17'd320, 24'hABCDEF, 24'd0, 8'h09, 32'h01020304));
    send_item(begin_item(FMT_NOSID, MAX_CHAN, 24'h000001, 24'd0, 8'h80, 32'h0));
    send_item(begin_item(FMT_STAMP, 17'h1FFFF, 24'h800000, 24'd0, 8'h7F, 32'h0));
    // reserved ids 0 and 1 go out as given
    send_item(begin_item(FMT_FULL, 17'd0, 24'h0F0F0F, 24'd0, 8'h55, 32'hAAAA5555));
    send_item(begin_item(FMT_CONT, 17'd1, 24'h0, 24'd0, 8'h00, 32'h0));
    items_sent += 14;
    send_item(data_item(8'hEE));  // closed: dropped

    // tiny chunks on a three-byte id, then chunk size changes mid-message
    set_chunk(17'd2);
    send_item(begin_item(FMT_CONT, 17'd400, 24'h0, 24'hFFFFFF, 8'h00, 32'h0));
    repeat (5) send_item(data_item(8'($urandom())));
    set_chunk(17'd0);        // acts as one byte per chunk
    repeat (2) send_item(data_item(8'($urandom())));
    set_chunk(17'h1FFFF);    // clamps to the largest chunk
    repeat (2) send_item(data_item(8'($urandom())));
    items_sent += 10;

    // --- random phases over chunk sizes, extremes included ---
    sizes = '{17'd1, 17'd2, 17'd3, 17'd7, CHUNK_RESET, MAX_CHUNK, 17'd0, 17'h1FFFF, 17'd0};
    sizes[8] = 17'($urandom_range(4, 200));
    foreach (sizes[p]) begin
      set_chunk(sizes[p]);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 4 == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_message();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("framed %0d items under %0d chunk size writes, %0d bytes checked",
             items_sent, settings, bytes_checked);
    $display("receiver held off %0d times for %0d cycles", holds, LONG_HOLD);
    if (fail_count == 0) begin
      $display("rtmp_chunk_stream_framer_unit regression: pass");
    end else begin
      $display("rtmp_chunk_stream_framer_unit regression: fail");
    end
    $finish;
  end

endmodule

### rtmp_chunk_stream_framer_unit.f
rtl/rcsf_pkg.sv
rtl/rcsf_if.sv
rtl/rcsf_ctrl.sv
rtl/rcsf_dp.sv
rtl/rtmp_chunk_stream_framer_unit.sv
rtl/rcsf_checker.sv
tb/rcsf_stream_checker.sv
tb/rtmp_chunk_stream_framer_unit_tb.sv
